FILE: hw/rtl/sdr_pkg.sv
// shared types and constants for the segment display refresh master
// no dependencies; used by every module under hw/rtl
package sdr_pkg;

    localparam logic [7:0] CMD_DATA    = 8'h40;
    localparam logic [7:0] CMD_ADDR    = 8'hC0;
    localparam logic [7:0] CMD_CTRL    = 8'h80;
    localparam logic [7:0] BRIGHT_MASK = 8'h07;
    localparam logic [7:0] ON_BIT      = 8'h08;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_REFRESH = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        TX_DATA = 2'd0,
        TX_ADDR = 2'd1,
        TX_CTRL = 2'd2
    } tx_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_BIT   = 2'd1,
        PH_ACK   = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic ack_missing;
        logic frame_done;
    } res_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

FILE: hw/rtl/sdr_engine.sv
// configuration registers, digit store, frame latch and two-wire slot sequencer; one step per accepted beat
// depends on sdr_pkg
module sdr_engine #(
    parameter int DIGITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sdr_pkg::cfg_wr_t                cfg_wr,
    input  logic                            step,
    input  logic [sdr_pkg::ACTION_W-1:0]    action,
    input  logic [sdr_pkg::INDEX_W-1:0]     digit_index,
    input  logic [7:0]                      segment_bits,
    input  logic                            dio_sample,
    output sdr_pkg::res_t                   res
);

    localparam int BYTE_W = (DIGITS + 1 > 1) ? $clog2(DIGITS + 1) : 1;

    logic [2:0]        brightness_reg;
    logic              display_on_reg;
    logic [7:0]        digit_store_reg [DIGITS];
    logic [7:0]        frame_digits_reg [DIGITS];

    sdr_pkg::tx_t      tx_reg, tx_next;
    sdr_pkg::phase_t   phase_reg, phase_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [2:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              clock_reg, clock_next;
    logic              data_reg, data_next;
    logic              sending_reg, sending_next;
    logic              ack_reg, ack_next;

    sdr_pkg::action_t  act;
    logic [7:0]        digit_byte;
    logic [7:0]        tx_byte;
    logic              last_byte;
    logic              start_frame;
    logic              done;

    assign act = sdr_pkg::action_t'(action);
    assign start_frame = step && (act == sdr_pkg::ACT_REFRESH) && !sending_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= '0;
            display_on_reg <= 1'b0;
        end
        else if (cfg_wr.we)
        begin
            unique case (cfg_wr.index)
                sdr_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_wr.data[2:0];
                sdr_pkg::REG_DISPLAY_ON: display_on_reg <= cfg_wr.data[0];
                default: ;
            endcase
        end
    end

    // digit store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                digit_store_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                if (step && (act == sdr_pkg::ACT_WRITE) && (int'(digit_index) == i))
                begin
                    digit_store_reg[i] <= segment_bits;
                end
            end
        end
    end

    // frame latch
    always_ff @(posedge clk)
    begin
        if (start_frame)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                frame_digits_reg[i] <= digit_store_reg[i];
            end
        end
    end

    // byte on the wire
    always_comb
    begin
        digit_byte = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (byte_reg == BYTE_W'(i + 1))
            begin
                digit_byte = frame_digits_reg[i];
            end
        end
    end

    always_comb
    begin
        unique case (tx_reg)
            sdr_pkg::TX_DATA: tx_byte = sdr_pkg::CMD_DATA;
            sdr_pkg::TX_ADDR: tx_byte = (byte_reg == '0) ? sdr_pkg::CMD_ADDR : digit_byte;
            sdr_pkg::TX_CTRL: tx_byte = sdr_pkg::CMD_CTRL
                                      | ({5'd0, brightness_reg} & sdr_pkg::BRIGHT_MASK)
                                      | (display_on_reg ? sdr_pkg::ON_BIT : 8'h00);
            default:          tx_byte = sdr_pkg::CMD_DATA;
        endcase
    end

    assign last_byte = (tx_reg == sdr_pkg::TX_ADDR) ? (byte_reg == BYTE_W'(DIGITS)) : 1'b1;

    // slot sequencer
    always_comb
    begin
        tx_next      = tx_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        clock_next   = clock_reg;
        data_next    = data_reg;
        sending_next = sending_reg;
        ack_next     = ack_reg;
        done         = 1'b0;

        if (step)
        begin
            unique case (act)
                sdr_pkg::ACT_TICK:
                begin
                    if (sending_reg)
                    begin
                        unique case (phase_reg)
                            sdr_pkg::PH_START:
                            begin
                                data_next  = 1'b0;
                                phase_next = sdr_pkg::PH_BIT;
                                cnt_next   = '0;
                                bit_next   = '0;
                                byte_next  = '0;
                            end
                            sdr_pkg::PH_BIT:
                            begin
                                case (cnt_reg)
                                    2'd0: clock_next = 1'b0;
                                    2'd1: data_next  = tx_byte[bit_reg];
                                    default: clock_next = 1'b1;
                                endcase
                                if (cnt_reg == 2'd2)
                                begin
                                    cnt_next = '0;
                                    if (bit_reg == 3'd7)
                                    begin
                                        phase_next = sdr_pkg::PH_ACK;
                                    end
                                    else
                                    begin
                                        bit_next = bit_reg + 3'd1;
                                    end
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + 2'd1;
                                end
                            end
                            sdr_pkg::PH_ACK:
                            begin
                                case (cnt_reg)
                                    2'd0:
                                    begin
                                        clock_next = 1'b0;
                                        data_next  = 1'b1;
                                    end
                                    2'd1: clock_next = 1'b1;
                                    2'd2:
                                    begin
                                        if (dio_sample)
                                        begin
                                            ack_next = 1'b1;
                                        end
                                        else
                                        begin
                                            data_next = 1'b0;
                                        end
                                    end
                                    default: clock_next = 1'b0;
                                endcase
                                cnt_next = cnt_reg + 2'd1;
                                if (cnt_reg == 2'd3)
                                begin
                                    cnt_next = '0;
                                    bit_next = '0;
                                    if (last_byte)
                                    begin
                                        phase_next = sdr_pkg::PH_STOP;
                                    end
                                    else
                                    begin
                                        byte_next  = byte_reg + BYTE_W'(1);
                                        phase_next = sdr_pkg::PH_BIT;
                                    end
                                end
                            end
                            sdr_pkg::PH_STOP:
                            begin
                                case (cnt_reg)
                                    2'd0: data_next  = 1'b0;
                                    2'd1: clock_next = 1'b1;
                                    default: data_next = 1'b1;
                                endcase
                                if (cnt_reg == 2'd2)
                                begin
                                    cnt_next   = '0;
                                    phase_next = sdr_pkg::PH_START;
                                    unique case (tx_reg)
                                        sdr_pkg::TX_DATA: tx_next = sdr_pkg::TX_ADDR;
                                        sdr_pkg::TX_ADDR: tx_next = sdr_pkg::TX_CTRL;
                                        default:
                                        begin
                                            tx_next      = sdr_pkg::TX_DATA;
                                            sending_next = 1'b0;
                                            done         = 1'b1;
                                        end
                                    endcase
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + 2'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                sdr_pkg::ACT_REFRESH:
                begin
                    if (!sending_reg)
                    begin
                        sending_next = 1'b1;
                        ack_next     = 1'b0;
                        tx_next      = sdr_pkg::TX_DATA;
                        phase_next   = sdr_pkg::PH_START;
                        cnt_next     = '0;
                        bit_next     = '0;
                        byte_next    = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg      <= sdr_pkg::TX_DATA;
            phase_reg   <= sdr_pkg::PH_START;
            cnt_reg     <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            clock_reg   <= 1'b0;
            data_reg    <= 1'b0;
            sending_reg <= 1'b0;
            ack_reg     <= 1'b0;
        end
        else
        begin
            tx_reg      <= tx_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            clock_reg   <= clock_next;
            data_reg    <= data_next;
            sending_reg <= sending_next;
            ack_reg     <= ack_next;
        end
    end

    assign res.clock_line  = clock_next;
    assign res.data_line   = data_next;
    assign res.busy_res    = sending_next;
    assign res.ack_missing = ack_next;
    assign res.frame_done  = done;

endmodule

FILE: hw/rtl/sdr_skid.sv
// result register with a skid stage so the input side can take one more result while the output stalls
// depends on sdr_pkg
module sdr_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sdr_pkg::res_t push_data,
    output logic          space,
    output logic          out_valid,
    input  logic          out_ready,
    output sdr_pkg::res_t out_data
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    sdr_pkg::res_t out_reg;
    sdr_pkg::res_t skid_reg;
    logic          pop;

    assign space     = !skid_valid_reg;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

FILE: hw/rtl/segment_display_two_wire_refresh.sv
// top level of the segment display refresh master over a two-wire link
// depends on sdr_pkg, sdr_engine and sdr_skid
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | to block  | in_valid / in_ready  | action, digit_index, segment_bits, dio_sample
//  out     | from blk  | out_valid / out_ready| clock_line, data_line, busy_res, ack_missing,
//          |           |                      | frame_done
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one beat per cycle while in_ready is high; its result goes to the output or skid register
// the slot sequencer advances one slot per tick beat, so a frame needs
// 3 * 32 + 28 * DIGITS tick beats
// reset clears the digit store, line levels, sequencer and configuration
// a stalled output fills the skid stage, after which in_ready drops; cfg is always ready
module segment_display_two_wire_refresh #(
    parameter int DIGITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sdr_pkg::ACTION_W-1:0]      action,
    input  logic [sdr_pkg::INDEX_W-1:0]       digit_index,
    input  logic [7:0]                        segment_bits,
    input  logic                              dio_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              clock_line,
    output logic                              data_line,
    output logic                              busy_res,
    output logic                              ack_missing,
    output logic                              frame_done,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sdr_pkg::cfg_wr_t cfg_wr;
    sdr_pkg::res_t    step_res;
    sdr_pkg::res_t    out_res;
    logic             step;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.we    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign step = in_valid && in_ready;

    sdr_engine #(
        .DIGITS (DIGITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .step         (step),
        .action       (action),
        .digit_index  (digit_index),
        .segment_bits (segment_bits),
        .dio_sample   (dio_sample),
        .res          (step_res)
    );

    sdr_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign clock_line  = out_res.clock_line;
    assign data_line   = out_res.data_line;
    assign busy_res    = out_res.busy_res;
    assign ack_missing = out_res.ack_missing;
    assign frame_done  = out_res.frame_done;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for segment_display_two_wire_refresh: digit writes, refresh frames
// and bit-timer ticks, checked beat by beat against a line-level predictor; needs sdr_pkg
module testbench;

    localparam int          DIGITS       = 4;
    localparam int unsigned BYTE_SLOTS   = 28;
    localparam int unsigned SHORT_TX     = 1 + BYTE_SLOTS + 3;
    localparam int unsigned LONG_TX      = 1 + BYTE_SLOTS * (DIGITS + 1) + 3;
    localparam int unsigned FRAME_SLOTS  = SHORT_TX + LONG_TX + SHORT_TX;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          PHASE_STEPS  = 255;
    localparam logic [sdr_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [sdr_pkg::ACTION_W-1:0] act;
        logic [sdr_pkg::INDEX_W-1:0]  idx;
        logic [7:0]                   seg;
        logic                         dio;
        int unsigned                  gap;
    } panel_step_t;

    logic                           clk;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic [sdr_pkg::ACTION_W-1:0]   action       = sdr_pkg::ACT_TICK;
    logic [sdr_pkg::INDEX_W-1:0]    digit_index  = '0;
    logic [7:0]                     segment_bits = '0;
    logic                           dio_sample   = 1'b0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic                           clock_line;
    logic                           data_line;
    logic                           busy_res;
    logic                           ack_missing;
    logic                           frame_done;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [sdr_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [sdr_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

    // predictor state
    logic [7:0]  digit_store  [DIGITS] = '{default: 8'h00};
    logic [7:0]  frame_digits [DIGITS] = '{default: 8'h00};
    int unsigned slot_count = 0;
    logic        clk_lvl    = 1'b0;
    logic        dat_lvl    = 1'b0;
    logic        sending    = 1'b0;
    logic        ack_flag   = 1'b0;
    logic [2:0]  cfg_bright = 3'd0;
    logic        cfg_on     = 1'b0;

    panel_step_t   step_queue [$];
    sdr_pkg::res_t level_due  [$];
    sdr_pkg::res_t seen_levels;
    sdr_pkg::res_t due_levels;

    int          snd_mode = 0;
    int          rcv_mode = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;
    int unsigned idle_cycles = 0;
    int unsigned queued_steps = 0;
    int unsigned steps_sent = 0;
    int unsigned results_checked = 0;
    int unsigned frames_seen = 0;
    int unsigned frames_nak = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;

    segment_display_two_wire_refresh #(
        .DIGITS (DIGITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .digit_index  (digit_index),
        .segment_bits (segment_bits),
        .dio_sample   (dio_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .clock_line   (clock_line),
        .data_line    (data_line),
        .busy_res     (busy_res),
        .ack_missing  (ack_missing),
        .frame_done   (frame_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_wait(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 19);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    endfunction

    function automatic logic [7:0] frame_byte(sdr_pkg::tx_t tx, int unsigned b);
        if (tx == sdr_pkg::TX_DATA)
            return sdr_pkg::CMD_DATA;
        if (tx == sdr_pkg::TX_ADDR)
        begin
            if (b == 0)
                return sdr_pkg::CMD_ADDR;
            return frame_digits[b - 1];
        end
        return sdr_pkg::CMD_CTRL | ({5'b0, cfg_bright} & sdr_pkg::BRIGHT_MASK)
               | (cfg_on ? sdr_pkg::ON_BIT : 8'h00);
    endfunction

    // one delay slot of the pin sequence
    function automatic void line_slot(int unsigned s, logic dio);
        sdr_pkg::tx_t tx;
        int unsigned  o;
        int unsigned  nb;
        int unsigned  r;
        logic [7:0]   byte_val;
        if (s < SHORT_TX)
        begin
            tx = sdr_pkg::TX_DATA;
            o  = s;
            nb = 1;
        end
        else if (s < SHORT_TX + LONG_TX)
        begin
            tx = sdr_pkg::TX_ADDR;
            o  = s - SHORT_TX;
            nb = DIGITS + 1;
        end
        else
        begin
            tx = sdr_pkg::TX_CTRL;
            o  = s - SHORT_TX - LONG_TX;
            nb = 1;
        end
        if (o == 0)
        begin
            dat_lvl = 1'b0;
            return;
        end
        o = o - 1;
        if (o < BYTE_SLOTS * nb)
        begin
            r = o % BYTE_SLOTS;
            if (r < 24)
            begin
                case (r % 3)
                    0: clk_lvl = 1'b0;
                    1:
                    begin
                        byte_val = frame_byte(tx, o / BYTE_SLOTS);
                        dat_lvl  = byte_val[r / 3];
                    end
                    default: clk_lvl = 1'b1;
                endcase
            end
            else if (r == 24)
            begin
                clk_lvl = 1'b0;
                dat_lvl = 1'b1;
            end
            else if (r == 25)
                clk_lvl = 1'b1;
            else if (r == 26)
            begin
                if (dio)
                    ack_flag = 1'b1;
                else
                    dat_lvl = 1'b0;
            end
            else
                clk_lvl = 1'b0;
            return;
        end
        o = o - BYTE_SLOTS * nb;
        if (o == 0)
            dat_lvl = 1'b0;
        else if (o == 1)
            clk_lvl = 1'b1;
        else
            dat_lvl = 1'b1;
    endfunction

    function automatic sdr_pkg::res_t advance_refresh(logic [sdr_pkg::ACTION_W-1:0] act,
                                                      logic [sdr_pkg::INDEX_W-1:0]  idx,
                                                      logic [7:0] seg, logic dio);
        sdr_pkg::res_t r;
        logic          done;
        done = 1'b0;
        if (act == sdr_pkg::ACT_TICK)
        begin
            if (sending)
            begin
                line_slot(slot_count, dio);
                if (slot_count + 1 >= FRAME_SLOTS)
                begin
                    sending    = 1'b0;
                    slot_count = 0;
                    done       = 1'b1;
                end
                else
                    slot_count = slot_count + 1;
            end
        end
        else if (act == sdr_pkg::ACT_WRITE)
        begin
            if (idx < DIGITS)
                digit_store[idx] = seg;
        end
        else if (act == sdr_pkg::ACT_REFRESH)
        begin
            if (!sending)
            begin
                frame_digits = digit_store;
                sending      = 1'b1;
                slot_count   = 0;
                ack_flag     = 1'b0;
            end
        end
        r.clock_line  = clk_lvl;
        r.data_line   = dat_lvl;
        r.busy_res    = sending;
        r.ack_missing = ack_flag;
        r.frame_done  = done;
        return r;
    endfunction

    function automatic void queue_step(logic [sdr_pkg::ACTION_W-1:0] act,
                                       logic [sdr_pkg::INDEX_W-1:0] idx,
                                       logic [7:0] seg, logic dio);
        panel_step_t st;
        st.act = act;
        st.idx = idx;
        st.seg = seg;
        st.dio = dio;
        st.gap = draw_wait(snd_mode);
        step_queue.push_back(st);
        queued_steps++;
    endfunction

    function automatic logic [7:0] pick_segments();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // digit writes, a refresh and a frame's worth of ticks, with some noise and truncation
    task automatic queue_frame();
        int unsigned n_wr;
        int unsigned n_tick;
        int unsigned k;
        n_wr = $urandom_range(0, 4);
        for (k = 0; k < n_wr; k++)
            queue_step(sdr_pkg::ACT_WRITE, 2'($urandom_range(0, 3)), pick_segments(),
                       1'($urandom));
        queue_step(sdr_pkg::ACT_REFRESH, 2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 7) == 0)
            n_tick = $urandom_range(0, FRAME_SLOTS);
        else
            n_tick = FRAME_SLOTS + $urandom_range(0, 6);
        for (k = 0; k < n_tick; k++)
        begin
            if ($urandom_range(0, 23) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: queue_step(sdr_pkg::ACT_WRITE, 2'($urandom_range(0, 3)),
                                  pick_segments(), 1'($urandom));
                    1: queue_step(sdr_pkg::ACT_REFRESH, 2'($urandom), 8'($urandom),
                                  1'($urandom));
                    default: queue_step(ACT_SPARE, 2'($urandom), 8'($urandom), 1'($urandom));
                endcase
            end
            queue_step(sdr_pkg::ACT_TICK, 2'($urandom), 8'($urandom),
                       ($urandom_range(0, 11) == 0) ? 1'b1 : 1'b0);
        end
    endtask

    task automatic write_reg(logic [sdr_pkg::CFG_IDX_W-1:0] idx,
                             logic [sdr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == sdr_pkg::REG_BRIGHTNESS)
            cfg_bright = val;
        else
            cfg_on = val[0];
        reg_writes++;
    endtask

    task automatic wait_drained();
        while (step_queue.size() != 0 || in_valid || level_due.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                level_due.push_back(advance_refresh(action, digit_index, segment_bits,
                                                    dio_sample));
                steps_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (step_queue.size() != 0)
                begin
                    in_valid     <= 1'b1;
                    action       <= step_queue[0].act;
                    digit_index  <= step_queue[0].idx;
                    segment_bits <= step_queue[0].seg;
                    dio_sample   <= step_queue[0].dio;
                    gap_left     <= step_queue[0].gap;
                    void'(step_queue.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_levels = {clock_line, data_line, busy_res, ack_missing, frame_done};
                results_checked++;
                if (frame_done)
                    frames_seen++;
                if (frame_done && ack_missing)
                    frames_nak++;
                if (level_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: beat with nothing expected: got %b", $time, seen_levels);
                end
                else
                begin
                    due_levels = level_due.pop_front();
                    if (seen_levels !== due_levels)
                    begin
                        mismatches++;
                        $display({"%0t: line mismatch expected clk=%b dat=%b busy=%b ",
                                  "ack=%b done=%b, got clk=%b dat=%b busy=%b ack=%b done=%b"},
                                 $time, due_levels.clock_line, due_levels.data_line,
                                 due_levels.busy_res, due_levels.ack_missing,
                                 due_levels.frame_done, seen_levels.clock_line,
                                 seen_levels.data_line, seen_levels.busy_res,
                                 seen_levels.ack_missing, seen_levels.frame_done);
                    end
                end
                stall_draw = draw_wait(rcv_mode);
                if (stall_draw != 0)
                begin
                    out_ready  <= 1'b0;
                    stall_left <= stall_draw - 1;
                end
            end
            else if (stall_left != 0)
                stall_left <= stall_left - 1;
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("segment_display_two_wire_refresh regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [sdr_pkg::CFG_DATA_W-1:0] bright_sets [6];
        logic [sdr_pkg::CFG_DATA_W-1:0] on_sets [6];
        int                             p;
        bright_sets = '{3'd7, 3'd3, 3'd0, 3'd7, 3'd0, 3'd5};
        on_sets     = '{3'b001, 3'b000, 3'b111, 3'b110, 3'b000, 3'b000};
        bright_sets[4] = 3'($urandom);
        on_sets[4]     = 3'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(sdr_pkg::REG_BRIGHTNESS, 3'd0);
        write_reg(sdr_pkg::REG_DISPLAY_ON, 3'd0);

        // directed: idle tick, spare code, extreme digits, refresh, busy cases
        snd_mode = 2;
        rcv_mode = 1;
        @(negedge clk);
        queue_step(sdr_pkg::ACT_TICK, 2'd3, 8'hFF, 1'b1);
        queue_step(ACT_SPARE, 2'd3, 8'hFF, 1'b1);
        queue_step(ACT_SPARE, 2'd0, 8'h00, 1'b0);
        queue_step(sdr_pkg::ACT_WRITE, 2'd0, 8'h00, 1'b0);
        queue_step(sdr_pkg::ACT_WRITE, 2'd1, 8'hFF, 1'b1);
        queue_step(sdr_pkg::ACT_WRITE, 2'd2, 8'hA5, 1'b0);
        queue_step(sdr_pkg::ACT_WRITE, 2'd3, 8'h5A, 1'b1);
        queue_step(sdr_pkg::ACT_REFRESH, 2'd0, 8'h00, 1'b0);
        queue_step(sdr_pkg::ACT_TICK, 2'd0, 8'h00, 1'b0);
        queue_step(sdr_pkg::ACT_REFRESH, 2'd3, 8'hFF, 1'b1);
        queue_step(sdr_pkg::ACT_WRITE, 2'd0, 8'h3C, 1'b0);
        queue_step(ACT_SPARE, 2'd1, 8'h81, 1'b1);
        repeat (12) queue_step(sdr_pkg::ACT_TICK, 2'd0, 8'h00, 1'b0);
        wait_drained();

        for (p = 0; p < 6; p++)
        begin
            write_reg(sdr_pkg::REG_BRIGHTNESS, bright_sets[p]);
            write_reg(sdr_pkg::REG_DISPLAY_ON, on_sets[p]);
            snd_mode = p % 3;
            rcv_mode = (p + 1) % 3;
            @(negedge clk);
            queued_steps = 0;
            while (queued_steps + FRAME_SLOTS < PHASE_STEPS)
                queue_frame();
            while (queued_steps < PHASE_STEPS)
                queue_step(sdr_pkg::ACT_TICK, 2'($urandom), 8'($urandom),
                           ($urandom_range(0, 11) == 0) ? 1'b1 : 1'b0);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (level_due.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, level_due.size());
            mismatches += level_due.size();
        end
        $display("covered %0d steps and %0d result beats over %0d register writes",
                 steps_sent, results_checked, reg_writes);
        $display("%0d frames finished, %0d of them with a missing ack, %0d mismatches",
                 frames_seen, frames_nak, mismatches);
        if (mismatches == 0)
            $display("segment_display_two_wire_refresh regression: pass");
        else
            $display("segment_display_two_wire_refresh regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_engine.sv
hw/rtl/sdr_skid.sv
hw/rtl/segment_display_two_wire_refresh.sv
tb/sv/testbench.sv
